// File: sv/epp_pkg.sv
// ----------------------------------------------------------------------------
// epp_pkg: shared types and constants of the equal-power panner
// Configuration bundle, fixed-point constants, divider sizing and the pan
// sine table, which is built at elaboration time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package epp_pkg;

  localparam int GAIN_ONE   = 4096;   // 1.0 in Q3.12
  localparam int DROP_BITS  = 39;     // fraction bits dropped from the full product
  localparam int PAN_LAST   = 180;    // highest pan table index
  localparam int PAN_DEPTH  = 181;
  localparam int MUL_BITS   = 32;     // shared multiplier operand width
  localparam int DIV_Q_BITS = 16;     // ramp quotient width
  localparam int DIV_D_BITS = 32;     // ramp length width
  localparam int DIV_N_BITS = DIV_D_BITS + DIV_Q_BITS;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic signed [7:0]  azimuth;
    logic signed [15:0] static_gain;
    logic               ramp_enable;
    logic signed [15:0] ramp_start_gain;
    logic signed [15:0] ramp_end_gain;
    logic [31:0]        ramp_length;
    logic [31:0]        ramp_position;
  } epp_cfg_t;

  typedef logic [15:0] pan_table_t [PAN_DEPTH];

  // Entry k holds the sine of k/2 degrees in unsigned Q1.15, from a Q30 series.
  function automatic pan_table_t build_pan_table();
    pan_table_t        tbl;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   r;
    longint            sum;
    for (int k = 0; k < PAN_DEPTH; k++) begin
      x    = (longint'(k) * PI_Q30 + 64'd180) / 64'd360;
      x2   = (x * x) >> 30;
      // alternating terms x^(2n+1) / (2n+1)! for n = 1 .. 7
      term = ((x * x2) >> 30) / 64'd6;
      sum  = longint'(x) - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      r = (longint'(sum) + 64'd16384) >> 15;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      tbl[k] = 16'(r);
    end
    return tbl;
  endfunction

  localparam pan_table_t PAN_TABLE = build_pan_table();

endpackage

`default_nettype wire

// File: sv/epp_regs.sv
// ----------------------------------------------------------------------------
// epp_regs: configuration register file
// APB-style write and read of the six pan and gain registers, plus the ramp
// position counter that advances once per ramped sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epp_regs
  import epp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        advance,
  output epp_cfg_t         cfg
);

  typedef enum logic [2:0] {
    REG_AZIMUTH     = 3'd0,
    REG_STATIC_GAIN = 3'd1,
    REG_RAMP_ENABLE = 3'd2,
    REG_RAMP_START  = 3'd3,
    REG_RAMP_END    = 3'd4,
    REG_RAMP_LENGTH = 3'd5
  } reg_idx_t;

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.azimuth         <= '0;
      cfg.static_gain     <= 16'(GAIN_ONE);
      cfg.ramp_enable     <= 1'b0;
      cfg.ramp_start_gain <= '0;
      cfg.ramp_end_gain   <= '0;
      cfg.ramp_length     <= '0;
      cfg.ramp_position   <= '0;
    end else begin
      if (advance) begin
        // hold at all ones instead of wrapping
        if (cfg.ramp_position != '1) begin
          cfg.ramp_position <= cfg.ramp_position + 32'd1;
        end
      end else if (wr && (idx == REG_RAMP_START || idx == REG_RAMP_END)) begin
        cfg.ramp_position <= '0;
      end
      if (wr) begin
        unique case (idx)
          REG_AZIMUTH:     cfg.azimuth         <= pwdata[7:0];
          REG_STATIC_GAIN: cfg.static_gain     <= pwdata[15:0];
          REG_RAMP_ENABLE: cfg.ramp_enable     <= pwdata[0];
          REG_RAMP_START:  cfg.ramp_start_gain <= pwdata[15:0];
          REG_RAMP_END:    cfg.ramp_end_gain   <= pwdata[15:0];
          REG_RAMP_LENGTH: cfg.ramp_length     <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_AZIMUTH:     prdata = {{24{cfg.azimuth[7]}}, cfg.azimuth};
      REG_STATIC_GAIN: prdata = {{16{cfg.static_gain[15]}}, cfg.static_gain};
      REG_RAMP_ENABLE: prdata = {31'd0, cfg.ramp_enable};
      REG_RAMP_START:  prdata = {{16{cfg.ramp_start_gain[15]}}, cfg.ramp_start_gain};
      REG_RAMP_END:    prdata = {{16{cfg.ramp_end_gain[15]}}, cfg.ramp_end_gain};
      REG_RAMP_LENGTH: prdata = cfg.ramp_length;
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/epp_mul.sv
// ----------------------------------------------------------------------------
// epp_mul: shared unsigned multiplier
// One 32 x 32 unsigned multiply per cycle with a registered 64-bit product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epp_mul
  import epp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [MUL_BITS-1:0]   a,
  input  wire logic [MUL_BITS-1:0]   b,
  output logic      [2*MUL_BITS-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= (2*MUL_BITS)'(a) * (2*MUL_BITS)'(b);
  end

endmodule

`default_nettype wire

// File: sv/epp_div.sv
// ----------------------------------------------------------------------------
// epp_div: serial ramp divider
// Restoring division, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor, so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epp_div
  import epp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIV_N_BITS-1:0] dividend,
  input  wire logic [DIV_D_BITS-1:0] divisor,
  output logic                       done,
  output logic      [DIV_Q_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIV_Q_BITS);

  logic [DIV_D_BITS-1:0] rem;
  logic [CNT_BITS-1:0]   cnt;
  logic                  busy;
  logic [DIV_D_BITS:0]   trial;
  logic                  fits;

  assign trial = {rem, quotient[DIV_Q_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(DIV_Q_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient doubles as the shift register of low dividend bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[DIV_N_BITS-1:DIV_Q_BITS];
      quotient <= dividend[DIV_Q_BITS-1:0];
    end else if (busy) begin
      rem      <= fits ? DIV_D_BITS'(trial - {1'b0, divisor}) : trial[DIV_D_BITS-1:0];
      quotient <= {quotient[DIV_Q_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: sv/equal_power_panner_gain_ramp_top.sv
// ----------------------------------------------------------------------------
// equal_power_panner_gain_ramp_top: mono to stereo equal-power panner
// Static gain, optional linear gain ramp and sine-table pan law, computed on
// one shared multiplier and a serial divider under a one-hot sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         in_valid/in_stall   mono_sample, block_end
//  output    out        out_valid/out_stall left/right_sample, flags, clip_count,
//                                           block_done
//  config    in/out     APB psel/penable    paddr, pwdata, prdata, pready
//
//  An item runs through the whole sequence before the next transfer; while a
//  ramp is running the sequence also passes through the serial 16-step
//  ramp divider. The divider and the shared multiplier set its length.
//  Reset is synchronous and needs no clearing pass.
//  The result waits in an output register; a stalled result delays the write
//  of the next one, which waits in S_OUT and holds the input stalled meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module equal_power_panner_gain_ramp_top
  import epp_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [4:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] mono_sample,
  input  wire logic                          block_end,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS+2:0]      left_sample,
  output logic signed [SAMPLE_BITS+2:0]      right_sample,
  output logic                               left_clipped,
  output logic                               right_clipped,
  output logic                               saturated,
  output logic      [COUNT_BITS-1:0]         clip_count,
  output logic                               block_done
);

  localparam int A_W = SAMPLE_BITS + 31;          // sample x gain magnitude
  localparam int P_W = SAMPLE_BITS + 47;          // full product with pan
  localparam int R_W = P_W - DROP_BITS;           // rounded magnitude
  localparam int O_W = SAMPLE_BITS + 3;
  localparam logic [P_W-1:0] RND     = P_W'(1) << (DROP_BITS - 1);
  localparam logic [R_W-1:0] LIMIT   = R_W'(1) << (SAMPLE_BITS + 2);
  localparam logic [R_W-1:0] ONE_MAG = R_W'(1) << (SAMPLE_BITS - 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_RMUL   = 13'b0000000000010,
    S_RSTART = 13'b0000000000100,
    S_RDIV   = 13'b0000000001000,
    S_GMUL   = 13'b0000000010000,
    S_AMUL   = 13'b0000000100000,
    S_ASAVE  = 13'b0000001000000,
    S_PLO    = 13'b0000010000000,
    S_PHI    = 13'b0000100000000,
    S_PACC   = 13'b0001000000000,
    S_FIN    = 13'b0010000000000,
    S_OUT    = 13'b0100000000000,
    S_SPARE  = 13'b1000000000000
  } state_t;

  state_t                    state;
  epp_cfg_t                  cfg;
  logic                      advance;
  logic                      accept;

  logic [MUL_BITS-1:0]       mul_a;
  logic [MUL_BITS-1:0]       mul_b;
  logic [2*MUL_BITS-1:0]     prod;
  logic                      div_done;
  logic [DIV_Q_BITS-1:0]     div_q;

  logic [SAMPLE_BITS-1:0]    ms;
  logic                      mono_neg;
  logic                      last;
  logic [31:0]               pos_used;
  logic [16:0]               ramp;
  logic [A_W-1:0]            a_reg;
  logic [P_W-1:0]            acc;
  logic                      ch;

  logic signed [O_W-1:0]     left_val;
  logic                      left_clip;
  logic                      left_sat;

  logic [SAMPLE_BITS-1:0]    mono_abs;
  logic [16:0]               start17;
  logic [16:0]               diff;
  logic [16:0]               diff_abs;
  logic [16:0]               sg17;
  logic [16:0]               sg_abs;
  logic [16:0]               ramp_abs;
  logic                      neg;
  logic signed [7:0]         az_c;
  logic [7:0]                k;
  logic [7:0]                pan_idx;
  logic [15:0]               pan;

  logic [R_W-1:0]            r;
  logic                      sat;
  logic [R_W-1:0]            rc;
  logic                      clip;
  logic [O_W-1:0]            rc_o;
  logic [O_W-1:0]            val;

  logic [COUNT_BITS:0]       count_sum;
  logic [COUNT_BITS-1:0]     count_next;
  logic [COUNT_BITS-1:0]     block_count;
  logic                      load_out;

  epp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .advance (advance),
    .cfg     (cfg)
  );

  epp_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  epp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_RSTART),
    .dividend (prod[DIV_N_BITS-1:0]),
    .divisor  (cfg.ramp_length),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign advance  = accept && cfg.ramp_enable;

  assign mono_abs = mono_sample[SAMPLE_BITS-1] ? (~mono_sample + SAMPLE_BITS'(1))
                                               : mono_sample;
  assign start17  = {cfg.ramp_start_gain[15], cfg.ramp_start_gain};
  assign diff     = {cfg.ramp_end_gain[15], cfg.ramp_end_gain} - start17;
  assign diff_abs = diff[16] ? (~diff + 17'd1) : diff;
  assign sg17     = {cfg.static_gain[15], cfg.static_gain};
  assign sg_abs   = sg17[16] ? (~sg17 + 17'd1) : sg17;
  assign ramp_abs = ramp[16] ? (~ramp + 17'd1) : ramp;
  assign neg      = mono_neg ^ sg17[16] ^ ramp[16];

  // clamp azimuth to the table range
  always_comb begin
    priority if (cfg.azimuth < -8'sd90) begin
      az_c = -8'sd90;
    end else if (cfg.azimuth > 8'sd90) begin
      az_c = 8'sd90;
    end else begin
      az_c = cfg.azimuth;
    end
  end

  assign k       = 8'(az_c + 8'sd90);
  assign pan_idx = ch ? k : (8'(PAN_LAST) - k);
  assign pan     = PAN_TABLE[pan_idx];

  always_comb begin
    unique case (state)
      S_RMUL: begin
        mul_a = MUL_BITS'(diff_abs[15:0]);
        mul_b = pos_used;
      end
      S_GMUL: begin
        mul_a = MUL_BITS'(sg_abs);
        mul_b = MUL_BITS'(ramp_abs);
      end
      S_AMUL: begin
        mul_a = MUL_BITS'(ms);
        mul_b = prod[MUL_BITS-1:0];
      end
      S_PLO: begin
        mul_a = a_reg[MUL_BITS-1:0];
        mul_b = MUL_BITS'(pan);
      end
      S_PHI: begin
        mul_a = MUL_BITS'(a_reg[A_W-1:MUL_BITS]);
        mul_b = MUL_BITS'(pan);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round, saturate and flag one channel
  always_comb begin
    r    = acc[P_W-1:DROP_BITS];
    sat  = neg ? (r > LIMIT) : (r > (LIMIT - R_W'(1)));
    rc   = sat ? (neg ? LIMIT : (LIMIT - R_W'(1))) : r;
    clip = sat | (rc > ONE_MAG);
    rc_o = rc[O_W-1:0];
    val  = neg ? (~rc_o + O_W'(1)) : rc_o;
  end

  assign count_sum  = (COUNT_BITS+1)'(block_count) + (COUNT_BITS+1)'(left_clip)
                    + (COUNT_BITS+1)'(clip);
  assign count_next = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
  assign load_out   = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ch          <= 1'b0;
      out_valid   <= 1'b0;
      block_count <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          ch <= 1'b0;
          if (in_valid) begin
            priority if (!cfg.ramp_enable) begin
              state <= S_GMUL;
            end else if (cfg.ramp_length == '0 ||
                         cfg.ramp_position >= cfg.ramp_length) begin
              state <= S_GMUL;
            end else begin
              state <= S_RMUL;
            end
          end
        end
        S_RMUL:   state <= S_RSTART;
        S_RSTART: state <= S_RDIV;
        S_RDIV: begin
          if (div_done) begin
            state <= S_GMUL;
          end
        end
        S_GMUL:  state <= S_AMUL;
        S_AMUL:  state <= S_ASAVE;
        S_ASAVE: state <= S_PLO;
        S_PLO:   state <= S_PHI;
        S_PHI:   state <= S_PACC;
        S_PACC:  state <= S_FIN;
        S_FIN: begin
          if (!ch) begin
            ch    <= 1'b1;
            state <= S_PLO;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            block_count <= last ? '0 : count_next;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ms       <= mono_abs;
      mono_neg <= mono_sample[SAMPLE_BITS-1];
      last     <= block_end;
      pos_used <= cfg.ramp_position;
      if (!cfg.ramp_enable) begin
        ramp <= 17'(GAIN_ONE);
      end else begin
        ramp <= {cfg.ramp_end_gain[15], cfg.ramp_end_gain};
      end
    end
    if (state == S_RDIV && div_done) begin
      ramp <= diff[16] ? (start17 - 17'(div_q)) : (start17 + 17'(div_q));
    end
    if (state == S_ASAVE) begin
      a_reg <= prod[A_W-1:0];
    end
    if (state == S_PHI) begin
      acc <= P_W'(prod) + RND;
    end
    if (state == S_PACC) begin
      acc <= acc + {prod[P_W-MUL_BITS-1:0], {MUL_BITS{1'b0}}};
    end
    if (state == S_FIN && !ch) begin
      left_val  <= val;
      left_clip <= clip;
      left_sat  <= sat;
    end
    // acc still holds the right channel while waiting in S_OUT
    if (load_out) begin
      left_sample   <= left_val;
      left_clipped  <= left_clip;
      right_sample  <= val;
      right_clipped <= clip;
      saturated     <= left_sat | sat;
      clip_count    <= count_next;
      block_done    <= last;
    end
  end

endmodule

`default_nettype wire

// File: dv/equal_power_panner_gain_ramp_top_tb.sv
// ----------------------------------------------------------------------------
// equal_power_panner_gain_ramp_top_tb: self-checking bench for the panner
// A scoreboard predicts every stereo result from the register settings it
// has seen written, the running ramp position and the per-block clip count.
// Directed samples cover the extremes first. Random render blocks follow
// under changing settings and changing idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module equal_power_panner_gain_ramp_top_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SEGMENTS       = 16;
  localparam int SEG_ITEMS      = 90;
  localparam int TAIL_CYCLES    = 60;

  localparam longint unsigned PI_Q30     = 64'd3373259426;
  localparam int              UNITY_GAIN = 4096;
  localparam int              DROP       = 39;
  localparam longint unsigned OUT_LIMIT  = 64'd1 << 18;
  localparam longint unsigned UNIT_MAG   = 64'd1 << 15;

  typedef enum int {
    REG_AZIMUTH,
    REG_STATIC_GAIN,
    REG_RAMP_ENABLE,
    REG_RAMP_START,
    REG_RAMP_END,
    REG_RAMP_LENGTH,
    REG_UNMAPPED
  } reg_index_e;

  typedef struct packed {
    logic signed [18:0] left_sample;
    logic signed [18:0] right_sample;
    logic               left_clipped;
    logic               right_clipped;
    logic               saturated;
    logic [15:0]        clip_count;
    logic               block_done;
  } stereo_t;

  class pan_scoreboard;
    logic signed [7:0]  azimuth;
    logic signed [15:0] static_gain;
    logic               ramp_enable;
    logic signed [15:0] ramp_start;
    logic signed [15:0] ramp_end;
    logic [31:0]        ramp_length;
    logic [31:0]        ramp_position;
    logic [15:0]        block_clips;
    longint unsigned    pan_sine [181];
    stereo_t            stereo_due [$];
    int                 errors;
    int                 checked;
    int                 clipped_seen;
    int                 saturated_seen;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      longint          rounded;
      // sine of k/2 degrees: Q30 Taylor series, then round to Q1.15
      for (int k = 0; k <= 180; k++) begin
        x    = (longint'(k) * PI_Q30 + 64'd180) / 64'd360;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
          term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
          acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0) begin
          acc = 0;
        end
        rounded    = (acc + 64'sd16384) >>> 15;
        pan_sine[k] = (rounded > 32768) ? 64'd32768 : longint'(rounded);
      end
      azimuth        = '0;
      static_gain    = 16'(UNITY_GAIN);
      ramp_enable    = 1'b0;
      ramp_start     = '0;
      ramp_end       = '0;
      ramp_length    = '0;
      ramp_position  = '0;
      block_clips    = '0;
      errors         = 0;
      checked        = 0;
      clipped_seen   = 0;
      saturated_seen = 0;
    endfunction

    function void note_write(reg_index_e idx, logic [31:0] value);
      case (idx)
        REG_AZIMUTH:     azimuth = value[7:0];
        REG_STATIC_GAIN: static_gain = value[15:0];
        REG_RAMP_ENABLE: ramp_enable = value[0];
        REG_RAMP_START: begin
          ramp_start    = value[15:0];
          ramp_position = '0;
        end
        REG_RAMP_END: begin
          ramp_end      = value[15:0];
          ramp_position = '0;
        end
        REG_RAMP_LENGTH: ramp_length = value;
        default: ;
      endcase
    endfunction

    function logic [18:0] finish_channel(longint unsigned mag, bit neg,
                                         output bit sat, output bit clip);
      longint unsigned lim;
      lim  = neg ? OUT_LIMIT : OUT_LIMIT - 1;
      sat  = (mag > lim);
      if (sat) begin
        mag = lim;
      end
      clip = sat || (mag > UNIT_MAG);
      return neg ? 19'(-mag) : 19'(mag);
    endfunction

    function void note_sample(logic signed [15:0] sample, logic last);
      stereo_t         r;
      longint          ramp;
      longint          diff;
      longint          mono;
      longint          sgain;
      longint unsigned dmag;
      longint unsigned q;
      longint unsigned ms;
      longint unsigned gmag;
      longint unsigned lmag;
      longint unsigned rmag;
      int              pan_idx;
      int unsigned     clip_sum;
      bit              neg;
      bit              lsat;
      bit              rsat;
      bit              lclip;
      bit              rclip;
      ramp = UNITY_GAIN;
      if (ramp_enable) begin
        if (ramp_length == 0 || ramp_position >= ramp_length) begin
          ramp = ramp_end;
        end else begin
          diff = longint'(ramp_end) - longint'(ramp_start);
          dmag = (diff < 0) ? -diff : diff;
          q    = (dmag * ramp_position) / ramp_length;
          ramp = (diff < 0) ? longint'(ramp_start) - longint'(q)
                            : longint'(ramp_start) + longint'(q);
        end
        // hold at the top instead of wrapping
        if (ramp_position != 32'hFFFF_FFFF) begin
          ramp_position++;
        end
      end
      pan_idx = azimuth;
      if (pan_idx < -90) begin
        pan_idx = -90;
      end
      if (pan_idx > 90) begin
        pan_idx = 90;
      end
      pan_idx = pan_idx + 90;
      mono  = sample;
      sgain = static_gain;
      ms    = (mono < 0) ? -mono : mono;
      gmag  = ((sgain < 0) ? -sgain : sgain) * ((ramp < 0) ? -ramp : ramp);
      neg   = (mono < 0) ^ (sgain < 0) ^ (ramp < 0);
      // round half away from zero on the magnitude
      lmag = (ms * gmag * pan_sine[180 - pan_idx] + (64'd1 << (DROP - 1))) >> DROP;
      rmag = (ms * gmag * pan_sine[pan_idx] + (64'd1 << (DROP - 1))) >> DROP;
      r.left_sample   = finish_channel(lmag, neg, lsat, lclip);
      r.right_sample  = finish_channel(rmag, neg, rsat, rclip);
      r.left_clipped  = lclip;
      r.right_clipped = rclip;
      r.saturated     = lsat | rsat;
      clip_sum        = block_clips + lclip + rclip;
      block_clips     = (clip_sum > 32'hFFFF) ? 16'hFFFF : 16'(clip_sum);
      r.clip_count    = block_clips;
      r.block_done    = last;
      if (last) begin
        block_clips = '0;
      end
      stereo_due.push_back(r);
    endfunction

    function void check_output(stereo_t got);
      stereo_t exp_r;
      if (stereo_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result with nothing expected L=%0d R=%0d", $time,
                   $signed(got.left_sample), $signed(got.right_sample));
        end
        return;
      end
      exp_r = stereo_due.pop_front();
      checked++;
      if (exp_r.left_clipped || exp_r.right_clipped) begin
        clipped_seen++;
      end
      if (exp_r.saturated) begin
        saturated_seen++;
      end
      if (got.left_sample !== exp_r.left_sample || got.right_sample !== exp_r.right_sample ||
          got.left_clipped !== exp_r.left_clipped ||
          got.right_clipped !== exp_r.right_clipped ||
          got.saturated !== exp_r.saturated || got.clip_count !== exp_r.clip_count ||
          got.block_done !== exp_r.block_done) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp L=%0d R=%0d clip=%b%b sat=%b cnt=%0d done=%b", $time,
                   $signed(exp_r.left_sample), $signed(exp_r.right_sample),
                   exp_r.left_clipped, exp_r.right_clipped, exp_r.saturated,
                   exp_r.clip_count, exp_r.block_done);
          $display("           got L=%0d R=%0d clip=%b%b sat=%b cnt=%0d done=%b",
                   $signed(got.left_sample), $signed(got.right_sample),
                   got.left_clipped, got.right_clipped, got.saturated,
                   got.clip_count, got.block_done);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst           = 1'b1;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [4:0]         paddr         = '0;
  logic [31:0]        pwdata        = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic signed [15:0] mono_sample   = '0;
  logic               block_end     = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic signed [18:0] left_sample;
  logic signed [18:0] right_sample;
  logic               left_clipped;
  logic               right_clipped;
  logic               saturated;
  logic [15:0]        clip_count;
  logic               block_done;

  pan_scoreboard board;
  stereo_t       seen;
  int            send_idle_pct = 0;
  int            stall_pct     = 0;
  bit            hold_request  = 1'b0;
  int            hold_left     = 0;
  int            quiet_cycles  = 0;
  int            sent          = 0;
  int            settings      = 0;

  equal_power_panner_gain_ramp_top dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mono_sample   (mono_sample),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_sample   (left_sample),
    .right_sample  (right_sample),
    .left_clipped  (left_clipped),
    .right_clipped (right_clipped),
    .saturated     (saturated),
    .clip_count    (clip_count),
    .block_done    (block_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic write_reg(input reg_index_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.note_write(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [15:0] value, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mono_sample <= value;
    block_end   <= last;
    do @(posedge clk); while (in_stall);
    board.note_sample(value, last);
    sent++;
  endtask

  // drop valid and hold off until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.stereo_due.size() != 0);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 69; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 69; end
      default: begin send_idle_pct = 13; stall_pct = 13; end
    endcase
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom);
      3: return 16'(UNITY_GAIN);
      default: return 16'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 255)) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic program_segment(input int seg);
    logic [31:0] len;
    int          az;
    case ((seg / 4) % 4)
      0: len = '0;
      1: len = $urandom_range(1, 64);
      2: len = $urandom;
      default: len = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(0, 7))
      0: az = -90;
      1: az = 90;
      2: az = $signed($urandom_range(0, 255)) - 128;
      default: az = $signed($urandom_range(0, 180)) - 90;
    endcase
    write_reg(REG_AZIMUTH, 32'(az));
    write_reg(REG_STATIC_GAIN, 32'(pick_gain()));
    write_reg(REG_RAMP_ENABLE, 32'((seg % 3) != 0));
    write_reg(REG_RAMP_START, 32'(pick_gain()));
    write_reg(REG_RAMP_END, 32'(pick_gain()));
    write_reg(REG_RAMP_LENGTH, len);
    settings++;
  endtask

  // compare each transfer on the result side, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.left_sample   = left_sample;
      seen.right_sample  = right_sample;
      seen.left_clipped  = left_clipped;
      seen.right_clipped = right_clipped;
      seen.saturated     = saturated;
      seen.clip_count    = clip_count;
      seen.block_done    = block_done;
      board.check_output(seen);
    end
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    board = new();
    wait (rst == 1'b0);
    @(posedge clk);

    // reset settings: unity gain, center pan, ramp off
    set_idle(0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'(-1), 1'b1);
    drain_results();

    // hard left at the largest gain, then clamped azimuth on both sides
    write_reg(REG_STATIC_GAIN, 32'h0000_7FFF);
    write_reg(REG_AZIMUTH, 32'(-90));
    settings++;
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0100, 1'b1);
    drain_results();
    write_reg(REG_AZIMUTH, 32'(-128));
    settings++;
    send_sample(16'sh8000, 1'b0);
    drain_results();
    write_reg(REG_AZIMUTH, 32'(127));
    settings++;
    send_sample(16'sh7FFF, 1'b1);
    drain_results();

    // most negative gain, hard right
    write_reg(REG_STATIC_GAIN, 32'h0000_8000);
    write_reg(REG_AZIMUTH, 32'(90));
    settings++;
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    drain_results();

    // short ramp from the lowest to the highest gain, run past its end
    write_reg(REG_STATIC_GAIN, 32'(UNITY_GAIN));
    write_reg(REG_AZIMUTH, 32'(45));
    write_reg(REG_RAMP_ENABLE, 32'd1);
    write_reg(REG_RAMP_START, 32'h0000_8000);
    write_reg(REG_RAMP_END, 32'h0000_7FFF);
    write_reg(REG_RAMP_LENGTH, 32'd4);
    settings++;
    for (int i = 0; i < 6; i++) begin
      send_sample(16'sd20000, i == 5);
    end
    drain_results();

    // zero length jumps straight to the end gain
    write_reg(REG_RAMP_LENGTH, 32'd0);
    settings++;
    send_sample(16'sd20000, 1'b0);
    drain_results();
    write_reg(REG_RAMP_ENABLE, 32'd0);
    settings++;
    send_sample(16'sd20000, 1'b1);
    drain_results();

    // a write outside the register map changes nothing
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_sample(16'(-1234), 1'b0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      program_segment(seg);
      set_idle(seg % 4);
      if (seg == 4) begin
        hold_request = 1'b1;
      end
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (seg == 9 && i == SEG_ITEMS / 2) begin
          drain_results();
        end
        send_sample(pick_sample(), $urandom_range(0, 19) == 0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.stereo_due.size() != 0) begin
      $display("%0d expected results never arrived", board.stereo_due.size());
      board.errors += board.stereo_due.size();
    end
    $display("Covered %0d samples over %0d register settings, %0d results compared",
             sent, settings, board.checked);
    $display("Results with a clipped channel: %0d, with saturation: %0d",
             board.clipped_seen, board.saturated_seen);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
